@@ rtl/nzts_pkg.sv @@
// shared types, constants and helpers for the nested zone timing stack
package nzts_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_END   = 2'd1,
    KIND_FRAME = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLOSED    = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_DROPPED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    logic [31:0] name;
    logic [63:0] start;
    logic [63:0] child;
    logic [31:0] seq;
  } entry_t;

  function automatic logic [3:0] depth_sat(input logic [LVL_W-1:0] d);
    logic [LVL_W+3:0] ext;
    ext = {4'b0, d};
    return (ext > (LVL_W + 4)'(15)) ? 4'hf : ext[3:0];
  endfunction

endpackage

@@ rtl/nzts_cell.sv @@
// one stack cell: holds an open zone and shifts with its neighbors on push or pop
module nzts_cell
  import nzts_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  entry_t   up_in,
  input  entry_t   dn_in,
  output entry_t   ent
);

  always_ff @(posedge clk) begin
    case (op)
      OP_PUSH: ent <= up_in;
      OP_POP:  ent <= dn_in;
      default: ent <= ent;
    endcase
  end

endmodule

@@ rtl/nested_zone_timing_stack_top.sv @@
// top level of the nested zone timing stack: control sequencer, cell chain and result register
//
// A zone begin that fits on the stack is pushed while the block stays idle and gives no result.
// A zone end or frame end is registered first; each zone it closes then takes a read of the top
// cell, then the close result and the pop that folds the inclusive time into the parent. An
// unmatched end adds a result of its own after the last read, a frame end that finds no open
// zone returns to idle, and a begin on a full stack gives a dropped result. All closes go through
// the single close datapath at the top cell, and an output stall holds the result state.
// The open zones sit in a chain of STACK_DEPTH cells with the newest zone in the first cell.
module nested_zone_timing_stack_top
  import nzts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] name_id,
  input  logic [63:0] timestamp,
  input  logic [31:0] thread_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] zone_name,
  output logic [31:0] zone_index,
  output logic [3:0]  zone_depth,
  output logic [63:0] start_time,
  output logic [63:0] end_time,
  output logic [63:0] inclusive_time,
  output logic [63:0] exclusive_time,
  output logic [31:0] bad_count,
  output logic [31:0] owner_thread,
  output logic        last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAPTURE,
    S_EMIT,
    S_SOLO
  } state_t;

  state_t           state;
  logic [LVL_W-1:0] level;
  logic [31:0]      bad_total;
  logic [31:0]      zone_counter;

  logic [1:0]       kind_r;
  logic [31:0]      name_r;
  logic [63:0]      t_r;
  logic [31:0]      thread_r;
  status_t          solo_st;

  logic             close_bad;
  logic [31:0]      close_name;
  logic [31:0]      close_seq;
  logic [3:0]       close_depth;
  logic [63:0]      close_start;
  logic [63:0]      close_end;
  logic [63:0]      close_incl;
  logic [63:0]      close_child;

  entry_t           cell_q [STACK_DEPTH];
  entry_t           push_ent;
  entry_t           top_dn;
  cell_op_t         op;

  logic             out_free;
  logic             full;
  logic             push_now;
  logic [64:0]      child_sum;
  logic [63:0]      excl;
  logic [31:0]      bad_inc;
  logic             emit_last;

  assign out_free  = !out_valid || out_ready;
  assign full      = (level == LVL_W'(STACK_DEPTH));
  assign in_ready  = (state == S_IDLE);
  assign push_now  = in_ready && in_valid && (kind == KIND_BEGIN) && !full;
  assign child_sum = {1'b0, cell_q[1].child} + {1'b0, close_incl};
  assign excl      = (close_incl > close_child) ? close_incl - close_child : 64'd0;
  assign bad_inc   = (bad_total == 32'hffff_ffff) ? bad_total : bad_total + 32'd1;
  assign emit_last = !close_bad || ((kind_r == KIND_FRAME) && (level == LVL_W'(1)));

  always_comb begin
    push_ent.name  = name_id;
    push_ent.start = timestamp;
    push_ent.child = 64'd0;
    push_ent.seq   = zone_counter;
    top_dn         = cell_q[1];
    top_dn.child   = child_sum[64] ? 64'hffff_ffff_ffff_ffff : child_sum[63:0];
    if (push_now) begin
      op = OP_PUSH;
    end else if (state == S_EMIT && out_free) begin
      op = OP_POP;
    end else begin
      op = OP_HOLD;
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    entry_t up_in;
    entry_t dn_in;
    if (g == 0) begin : g_first
      assign up_in = push_ent;
      assign dn_in = top_dn;
    end else if (g == STACK_DEPTH - 1) begin : g_end
      assign up_in = cell_q[g-1];
      assign dn_in = '0;
    end else begin : g_mid
      assign up_in = cell_q[g-1];
      assign dn_in = cell_q[g+1];
    end
    nzts_cell u_cell (
      .clk   (clk),
      .op    (op),
      .up_in (up_in),
      .dn_in (dn_in),
      .ent   (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      level        <= '0;
      bad_total    <= '0;
      zone_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT && state != S_SOLO) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r   <= kind;
            name_r   <= name_id;
            t_r      <= timestamp;
            thread_r <= thread_id;
            case (kind)
              KIND_BEGIN: begin
                if (full) begin
                  solo_st <= ST_DROPPED;
                  state   <= S_SOLO;
                end else begin
                  level        <= level + LVL_W'(1);
                  zone_counter <= zone_counter + 32'd1;
                end
              end
              KIND_END, KIND_FRAME: state <= S_CAPTURE;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CAPTURE: begin
          if (level == '0) begin
            if (kind_r == KIND_FRAME) begin
              bad_total    <= '0;
              zone_counter <= '0;
              state        <= S_IDLE;
            end else begin
              solo_st <= ST_UNMATCHED;
              state   <= S_SOLO;
            end
          end else begin
            close_bad   <= (kind_r == KIND_FRAME) || (cell_q[0].name != name_r);
            close_name  <= cell_q[0].name;
            close_seq   <= cell_q[0].seq;
            close_depth <= depth_sat(level - LVL_W'(1));
            close_start <= cell_q[0].start;
            close_child <= cell_q[0].child;
            close_end   <= (t_r > cell_q[0].start) ? t_r : cell_q[0].start;
            close_incl  <= (t_r > cell_q[0].start) ? t_r - cell_q[0].start : 64'd0;
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= close_bad ? ST_MALFORMED : ST_CLOSED;
            zone_name      <= close_name;
            zone_index     <= close_seq;
            zone_depth     <= close_depth;
            start_time     <= close_start;
            end_time       <= close_end;
            inclusive_time <= close_incl;
            exclusive_time <= excl;
            bad_count      <= close_bad ? bad_inc : bad_total;
            owner_thread   <= thread_r;
            last           <= emit_last;
            level          <= level - LVL_W'(1);
            if (close_bad && !(emit_last && (kind_r == KIND_FRAME))) begin
              bad_total <= bad_inc;
            end
            if (emit_last) begin
              state <= S_IDLE;
              if (kind_r == KIND_FRAME) begin
                bad_total    <= '0;
                zone_counter <= '0;
              end
            end else begin
              state <= S_CAPTURE;
            end
          end
        end
        S_SOLO: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= solo_st;
            zone_name      <= name_r;
            start_time     <= t_r;
            end_time       <= t_r;
            inclusive_time <= 64'd0;
            exclusive_time <= 64'd0;
            owner_thread   <= thread_r;
            last           <= 1'b1;
            if (solo_st == ST_DROPPED) begin
              zone_index <= zone_counter;
              zone_depth <= depth_sat(LVL_W'(STACK_DEPTH));
              bad_count  <= bad_total;
            end else begin
              zone_index <= 32'd0;
              zone_depth <= 4'd0;
              bad_count  <= bad_inc;
              bad_total  <= bad_inc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
